[rtl/hss_pkg.sv]
//------------------------------------------------------------------------------
// hss_pkg
// Shared types, codes and the half-step phase table of the stepper sequencer.
//------------------------------------------------------------------------------
`default_nettype none

package hss_pkg;

    localparam int COUNT_BITS_DEF = 16;
    localparam int CFG_W          = 16;
    localparam int APB_DW         = 32;
    localparam int APB_AW         = 4;

    // register indexes, byte address is 4 * index
    localparam logic [1:0] REG_PRERUN  = 2'd0;
    localparam logic [1:0] REG_SEEK    = 2'd1;
    localparam logic [1:0] REG_SLOT    = 2'd2;
    localparam logic [1:0] REG_REVERSE = 2'd3;

    localparam logic [CFG_W-1:0] PRERUN_RST = 16'd4296;
    localparam logic [CFG_W-1:0] SEEK_RST   = 16'd12288;
    localparam logic [CFG_W-1:0] SLOT_RST   = 16'd512;

    // command codes carried by each tick
    localparam logic [1:0] MODE_TICK   = 2'd0;
    localparam logic [1:0] MODE_CALIB  = 2'd1;
    localparam logic [1:0] MODE_ROTATE = 2'd2;
    localparam logic [1:0] MODE_OFF    = 2'd3;

    typedef enum logic [1:0] {
        OP_IDLE   = 2'd0,
        OP_PRERUN = 2'd1,
        OP_SEEK   = 2'd2,
        OP_ROTATE = 2'd3
    } op_t;

    typedef struct packed {
        logic [CFG_W-1:0] prerun_steps;
        logic [CFG_W-1:0] seek_limit;
        logic [CFG_W-1:0] slot_steps;
        logic             reverse;
    } cfg_t;

    typedef struct packed {
        logic [3:0] coils;
        logic       busy_res;
        logic       done_res;
        logic       seek_error;
    } res_t;

    function automatic logic [3:0] phase_coils(input logic [2:0] phase);
        logic [3:0] pat;
        unique case (phase)
            3'd0:    pat = 4'b0001;
            3'd1:    pat = 4'b0011;
            3'd2:    pat = 4'b0010;
            3'd3:    pat = 4'b0110;
            3'd4:    pat = 4'b0100;
            3'd5:    pat = 4'b1100;
            3'd6:    pat = 4'b1000;
            default: pat = 4'b1001;
        endcase
        return pat;
    endfunction

endpackage

`default_nettype wire

[rtl/hss_if.sv]
//------------------------------------------------------------------------------
// hss channel interfaces
// Valid/ready channels for step ticks and for the per-tick results.
//------------------------------------------------------------------------------
`default_nettype none

interface hss_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic       opto_aligned;

    modport source (output valid, output mode, output opto_aligned, input ready);
    modport sink   (input valid, input mode, input opto_aligned, output ready);
endinterface

interface hss_res_if;
    logic       valid;
    logic       ready;
    logic [3:0] coils;
    logic       busy_res;
    logic       done_res;
    logic       seek_error;

    modport source (output valid, output coils, output busy_res, output done_res,
                    output seek_error, input ready);
    modport sink   (input valid, input coils, input busy_res, input done_res,
                    input seek_error, output ready);
endinterface

`default_nettype wire

[rtl/hss_cfg_regs.sv]
//------------------------------------------------------------------------------
// hss_cfg_regs
// APB register file holding step counts and the direction bit.
//------------------------------------------------------------------------------
`default_nettype none

module hss_cfg_regs
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [hss_pkg::APB_AW-1:0] paddr,
    input  wire logic [hss_pkg::APB_DW-1:0] pwdata,
    output logic      [hss_pkg::APB_DW-1:0] prdata,
    output logic                            pready,
    output hss_pkg::cfg_t                   cfg
);
    import hss_pkg::*;

    logic [CFG_W-1:0] prerun_reg;
    logic [CFG_W-1:0] seek_reg;
    logic [CFG_W-1:0] slot_reg;
    logic             reverse_reg;
    logic             wr_en;
    logic [1:0]       reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prerun_reg  <= PRERUN_RST;
            seek_reg    <= SEEK_RST;
            slot_reg    <= SLOT_RST;
            reverse_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_PRERUN:  prerun_reg  <= pwdata[CFG_W-1:0];
                REG_SEEK:    seek_reg    <= pwdata[CFG_W-1:0];
                REG_SLOT:    slot_reg    <= pwdata[CFG_W-1:0];
                default:     reverse_reg <= pwdata[0];
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_PRERUN: prdata = APB_DW'(prerun_reg);
            REG_SEEK:   prdata = APB_DW'(seek_reg);
            REG_SLOT:   prdata = APB_DW'(slot_reg);
            default:    prdata = APB_DW'(reverse_reg);
        endcase
    end

    assign cfg.prerun_steps = prerun_reg;
    assign cfg.seek_limit   = seek_reg;
    assign cfg.slot_steps   = slot_reg;
    assign cfg.reverse      = reverse_reg;

endmodule

`default_nettype wire

[rtl/hss_seq_core.sv]
//------------------------------------------------------------------------------
// hss_seq_core
// Operation state, step counter and phase index, updated once per tick.
//------------------------------------------------------------------------------
`default_nettype none

module hss_seq_core
#(
    parameter int COUNT_BITS = hss_pkg::COUNT_BITS_DEF
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          accept,
    input  wire logic [1:0]    mode,
    input  wire logic          opto_aligned,
    input  wire hss_pkg::cfg_t cfg,
    output hss_pkg::res_t      res
);
    import hss_pkg::*;

    localparam int CMP_W = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;
    localparam logic [CMP_W-1:0] CNT_MAX = CMP_W'({COUNT_BITS{1'b1}});

    op_t                  op_reg, op_next, op_eff;
    logic [COUNT_BITS-1:0] cnt_reg, cnt_next, cnt_eff, cnt_inc;
    logic [2:0]           phase_reg, phase_next, phase_step;
    logic [3:0]           coil_reg, coil_next;
    logic [CMP_W-1:0]     pre_lim, seek_lim, slot_lim, cnt_ext, inc_ext;
    logic                 seek_over, slot_reached, slot_after;
    logic                 done, err;

    // register values beyond the counter range act as its maximum
    function automatic logic [CMP_W-1:0] sat_lim(input logic [CFG_W-1:0] r);
        logic [CMP_W-1:0] v;
        v = CMP_W'(r);
        return (v > CNT_MAX) ? CNT_MAX : v;
    endfunction

    assign pre_lim  = sat_lim(cfg.prerun_steps);
    assign seek_lim = sat_lim(cfg.seek_limit);
    assign slot_lim = sat_lim(cfg.slot_steps);

    // next state: start commands, prerun to seek hand-over, finish conditions
    always_comb
    begin
        op_eff  = op_reg;
        cnt_eff = cnt_reg;
        if (op_reg == OP_IDLE && mode == MODE_CALIB)
        begin
            op_eff  = OP_PRERUN;
            cnt_eff = '0;
        end
        else if (op_reg == OP_IDLE && mode == MODE_ROTATE)
        begin
            op_eff  = OP_ROTATE;
            cnt_eff = '0;
        end
        if (op_eff == OP_PRERUN && CMP_W'(cnt_eff) >= pre_lim)
        begin
            op_eff  = OP_SEEK;
            cnt_eff = '0;
        end

        cnt_inc      = cnt_eff + COUNT_BITS'(1);
        cnt_ext      = CMP_W'(cnt_eff);
        inc_ext      = CMP_W'(cnt_inc);
        seek_over    = cnt_ext >= seek_lim;
        slot_reached = cnt_ext >= slot_lim;
        slot_after   = inc_ext >= slot_lim;

        if (mode == MODE_OFF)
        begin
            op_next = OP_IDLE;
        end
        else
        begin
            unique case (op_eff)
                OP_PRERUN: op_next = OP_PRERUN;
                OP_SEEK:   op_next = (opto_aligned || seek_over) ? OP_IDLE : OP_SEEK;
                OP_ROTATE: op_next = (slot_reached || slot_after) ? OP_IDLE : OP_ROTATE;
                default:   op_next = OP_IDLE;
            endcase
        end
    end

    assign phase_step = cfg.reverse ? (phase_reg - 3'd1) : (phase_reg + 3'd1);

    // datapath and result flags
    always_comb
    begin
        cnt_next   = cnt_eff;
        phase_next = phase_reg;
        coil_next  = coil_reg;
        done       = 1'b0;
        err        = 1'b0;
        if (mode == MODE_OFF)
        begin
            cnt_next  = '0;
            coil_next = 4'd0;
        end
        else
        begin
            unique case (op_eff)
                OP_PRERUN:
                begin
                    phase_next = phase_step;
                    coil_next  = phase_coils(phase_step);
                    cnt_next   = cnt_inc;
                end
                OP_SEEK:
                begin
                    if (opto_aligned)
                    begin
                        done = 1'b1;
                    end
                    else
                    begin
                        phase_next = phase_step;
                        coil_next  = phase_coils(phase_step);
                        cnt_next   = cnt_inc;
                        if (seek_over)
                        begin
                            done = 1'b1;
                            err  = 1'b1;
                        end
                    end
                end
                OP_ROTATE:
                begin
                    if (slot_reached)
                    begin
                        done = 1'b1;
                    end
                    else
                    begin
                        phase_next = phase_step;
                        coil_next  = phase_coils(phase_step);
                        cnt_next   = cnt_inc;
                        done       = slot_after;
                    end
                end
                default: ;
            endcase
            // finishing clears the counter and de-energizes the coils
            if (done)
            begin
                cnt_next  = '0;
                coil_next = 4'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg    <= OP_IDLE;
            cnt_reg   <= '0;
            phase_reg <= 3'd0;
            coil_reg  <= 4'd0;
        end
        else if (accept)
        begin
            op_reg    <= op_next;
            cnt_reg   <= cnt_next;
            phase_reg <= phase_next;
            coil_reg  <= coil_next;
        end
    end

    assign res.coils      = coil_next;
    assign res.busy_res   = (op_next != OP_IDLE);
    assign res.done_res   = done;
    assign res.seek_error = err;

endmodule

`default_nettype wire

[rtl/hss_out_stage.sv]
//------------------------------------------------------------------------------
// hss_out_stage
// Result register; reloads in the same cycle the previous result is taken.
//------------------------------------------------------------------------------
`default_nettype none

module hss_out_stage
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          load,
    input  wire hss_pkg::res_t res_in,
    output logic               room,
    hss_res_if.source          res
);
    import hss_pkg::*;

    logic valid_reg;
    res_t data_reg;

    assign room = !valid_reg || res.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= res_in;
        end
    end

    assign res.valid      = valid_reg;
    assign res.coils      = data_reg.coils;
    assign res.busy_res   = data_reg.busy_res;
    assign res.done_res   = data_reg.done_res;
    assign res.seek_error = data_reg.seek_error;

endmodule

`default_nettype wire

[rtl/half_step_stepper_sequencer.sv]
//------------------------------------------------------------------------------
// half_step_stepper_sequencer
// Half-step four-coil stepper sequencer with index seek calibration.
//
//   channel | dir | handshake          | payload
//   --------+-----+--------------------+----------------------------------------
//   cmd     | in  | valid/ready        | mode[1:0], opto_aligned
//   res     | out | valid/ready        | coils[3:0], busy_res, done_res, seek_error
//   apb     | in  | psel/penable/pready| paddr[3:0], pwdata/prdata[31:0]
//
// one tick per cycle unless res stalls: each transaction is resolved in one
// pass between the state registers and the result register, one result per tick
// a new tick is taken whenever the result register is empty or being emptied
// reset leaves the core coils off, phase index 0, idle, registers at defaults
// a stall on res holds the result and stops cmd; no state changes while stalled
//------------------------------------------------------------------------------
`default_nettype none

module half_step_stepper_sequencer
#(
    parameter int COUNT_BITS = hss_pkg::COUNT_BITS_DEF
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    hss_cmd_if.sink                         cmd,
    hss_res_if.source                       res,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [hss_pkg::APB_AW-1:0] paddr,
    input  wire logic [hss_pkg::APB_DW-1:0] pwdata,
    output logic      [hss_pkg::APB_DW-1:0] prdata,
    output logic                            pready
);
    import hss_pkg::*;

    cfg_t cfg;
    res_t res_comb;
    logic room;
    logic accept;

    assign cmd.ready = room;
    assign accept    = cmd.valid && room;

    hss_cfg_regs u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    hss_seq_core #(.COUNT_BITS(COUNT_BITS)) u_core
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .mode         (cmd.mode),
        .opto_aligned (cmd.opto_aligned),
        .cfg          (cfg),
        .res          (res_comb)
    );

    hss_out_stage u_out
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (accept),
        .res_in (res_comb),
        .room   (room),
        .res    (res)
    );

endmodule

`default_nettype wire
